FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the compactor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define NROC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define NROC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NROC_ASSERT(lbl, prop, msg)

`define NROC_ASSERT_RST(lbl, prop, msg)

`endif

`endif

FILE: sv/nroc_pkg.sv
// Shared types, codes and helpers of the NaN row omit compactor.
`timescale 1ns / 1ps

package nroc_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;
  localparam int ROW_CNT_W  = 9;
  localparam int COL_CNT_W  = 5;
  localparam int WORD_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] EXP_MASK  = 32'h7f80_0000;
  localparam logic [WORD_W-1:0] MANT_MASK = 32'h007f_ffff;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic restart;
    logic scan_init;
    logic scan_step;
    logic take_first;
    logic read_issue;
    logic adv_row;
    logic adv_col;
    logic out_nodata;
    logic out_data;
    logic last;
  } nroc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_last;
    logic surv_after_zero;
    logic surv_zero;
    logic scan_end;
    logic scan_kept;
    logic col_last;
  } nroc_sts_t;

  // NA pattern is a NaN as well, so the plain NaN test covers it
  function automatic logic is_nan(logic [WORD_W-1:0] b);
    return ((b & EXP_MASK) == EXP_MASK) && ((b & MANT_MASK) != '0);
  endfunction

endpackage

FILE: sv/nroc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module nroc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/nroc_datapath.sv
// Datapath: config registers, drop marks, counters, element store, result register.
`timescale 1ns / 1ps

module nroc_datapath import nroc_pkg::*; #(
  parameter int ROWS_MAX = 256,
  parameter int COLS_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [WORD_W-1:0]     value_bits,
  input  nroc_cmd_t             cmd,
  output nroc_sts_t             sts,
  output logic                  result_strobe,
  output logic [WORD_W-1:0]     out_bits,
  output logic                  is_last,
  output logic                  status,
  output logic [ROW_CNT_W-1:0]  kept_rows
);

  localparam int RW    = $clog2(ROWS_MAX + 1);
  localparam int RIW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int CNW   = $clog2(COLS_MAX + 1);
  localparam int CIW   = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int DEPTH = ROWS_MAX * COLS_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ROW_CNT_W-1:0] row_count, row_count_next;
  logic [COL_CNT_W-1:0] column_count, column_count_next;
  logic [ROWS_MAX-1:0]  marks;
  logic [RIW-1:0]       load_row;
  logic [CIW-1:0]       load_col;
  logic [AW-1:0]        load_addr;
  logic [RW-1:0]        surviving;
  logic [RW-1:0]        scan_row;
  logic [RIW-1:0]       emit_row;
  logic [RIW-1:0]       first_kept;
  logic [CIW-1:0]       emit_col;
  logic [AW-1:0]        col_base;
  logic [RW-1:0]        rows, rows_next;
  logic [CNW-1:0]       cols;
  logic                 load_drop;
  logic                 load_dec;
  logic                 row_wrap;
  logic [WORD_W-1:0]    rd_data;

  function automatic logic [RW-1:0] clamp_rows(logic [ROW_CNT_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) return RW'(1);
    if (x > 32'(ROWS_MAX)) return RW'(ROWS_MAX);
    return RW'(x);
  endfunction

  function automatic logic [CNW-1:0] clamp_cols(logic [COL_CNT_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) return CNW'(1);
    if (x > 32'(COLS_MAX)) return CNW'(COLS_MAX);
    return CNW'(x);
  endfunction

  always_comb begin
    row_count_next    = row_count;
    column_count_next = column_count;
    if (cfg_we && cfg_index == CFG_ROW_COUNT) begin
      row_count_next = cfg_data[ROW_CNT_W-1:0];
    end
    if (cfg_we && cfg_index == CFG_COLUMN_COUNT) begin
      column_count_next = cfg_data[COL_CNT_W-1:0];
    end
  end

  assign rows      = clamp_rows(row_count);
  assign rows_next = clamp_rows(row_count_next);
  assign cols      = clamp_cols(column_count);

  assign load_drop = is_nan(value_bits);
  assign load_dec  = load_drop && !marks[load_row];
  assign row_wrap  = (RW'(load_row) == rows - RW'(1));

  assign sts.load_last       = row_wrap && (CNW'(load_col) == cols - CNW'(1));
  assign sts.surv_after_zero = (surviving - RW'(load_dec)) == '0;
  assign sts.surv_zero       = (surviving == '0);
  assign sts.scan_end        = (scan_row >= rows);
  assign sts.scan_kept       = (scan_row < rows) && !marks[scan_row[RIW-1:0]];
  assign sts.col_last        = (CNW'(emit_col) == cols - CNW'(1));

  nroc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load),
    .waddr(load_addr),
    .wdata(value_bits),
    .re   (cmd.read_issue),
    .raddr(col_base + AW'(emit_row)),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_CNT_W'(1);
      column_count <= COL_CNT_W'(1);
      marks        <= '0;
      load_row     <= '0;
      load_col     <= '0;
      load_addr    <= '0;
      surviving    <= RW'(1);
      scan_row     <= '0;
      emit_row     <= '0;
      first_kept   <= '0;
      emit_col     <= '0;
      col_base     <= '0;
    end else begin
      row_count    <= row_count_next;
      column_count <= column_count_next;
      if (cfg_we || cmd.restart) begin
        marks     <= '0;
        load_row  <= '0;
        load_col  <= '0;
        load_addr <= '0;
        surviving <= rows_next;
        emit_row  <= '0;
        emit_col  <= '0;
        col_base  <= '0;
      end else begin
        if (cmd.load) begin
          if (load_dec) begin
            marks[load_row] <= 1'b1;
            surviving       <= surviving - RW'(1);
          end
          if (row_wrap) begin
            load_row <= '0;
            load_col <= load_col + CIW'(1);
          end else begin
            load_row <= load_row + RIW'(1);
          end
          load_addr <= load_addr + AW'(1);
        end
        if (cmd.take_first) begin
          first_kept <= scan_row[RIW-1:0];
          emit_row   <= scan_row[RIW-1:0];
        end
        if (cmd.adv_row) begin
          emit_row <= scan_row[RIW-1:0];
        end
        if (cmd.adv_col) begin
          emit_col <= emit_col + CIW'(1);
          col_base <= col_base + AW'(rows);
          emit_row <= first_kept;
        end
      end
      if (cmd.scan_init) begin
        scan_row <= '0;
      end else if (cmd.read_issue) begin
        scan_row <= RW'(emit_row) + RW'(1);
      end else if (cmd.scan_step) begin
        scan_row <= scan_row + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.out_nodata || cmd.out_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_data) begin
      out_bits  <= rd_data;
      is_last   <= cmd.last;
      status    <= 1'b0;
      kept_rows <= ROW_CNT_W'(surviving);
    end else if (cmd.out_nodata) begin
      out_bits  <= '0;
      is_last   <= 1'b0;
      status    <= 1'b1;
      kept_rows <= '0;
    end
  end

endmodule

FILE: sv/nroc_ctrl.sv
// Controller state machine: load, first-row search, emit, next-row search.
`timescale 1ns / 1ps

module nroc_ctrl import nroc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      start,
  input  logic      req_type,
  input  nroc_sts_t sts,
  output nroc_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_FIRST = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_NEXT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = (state == ST_FIRST) || (state == ST_NEXT);
  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && req_type) begin
          cmd.out_nodata = 1'b1;
        end else if (accept) begin
          cmd.load = 1'b1;
          if (sts.load_last) begin
            if (sts.surv_after_zero) begin
              state_next = ST_EMIT;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = ST_FIRST;
            end
          end
        end
      end
      ST_FIRST: begin
        if (sts.scan_kept) begin
          cmd.take_first = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (accept && req_type) begin
          if (sts.surv_zero) begin
            cmd.out_nodata = 1'b1;
            cmd.restart    = 1'b1;
            state_next     = ST_LOAD;
          end else begin
            cmd.read_issue = 1'b1;
            state_next     = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (sts.scan_kept) begin
          cmd.out_data = 1'b1;
          cmd.adv_row  = 1'b1;
          state_next   = ST_EMIT;
        end else if (sts.scan_end) begin
          cmd.out_data = 1'b1;
          cmd.last     = sts.col_last;
          if (sts.col_last) begin
            cmd.restart = 1'b1;
            state_next  = ST_LOAD;
          end else begin
            cmd.adv_col = 1'b1;
            state_next  = ST_EMIT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
    if (cfg_we) begin
      state_next = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/nan_row_omit_compactor_unit.sv
// Top level of the NaN row omit compactor.
//
// Command channel: a beat is taken at a clock edge with start high and busy low.
// req_type 0 loads one element (value_bits) in column-major order and gives no
// result. req_type 1 asks for the next kept element. Results: result_strobe
// marks one cycle with out_bits, is_last, status and kept_rows; it cannot be
// held off. A request while loading, or when no row is kept, returns status 1
// in the cycle after the beat. A data request raises busy while the next-row
// search steps over the drop marks (to the end of the column on a column
// change), and the result is registered when the search ends. After the last
// load, busy is high while the search finds the first kept row, unless no row
// is kept. Loads while emitting are dropped. Config channel: cfg_ready is always
// high; writing row_count (index 0) or column_count (index 1) restarts the
// matrix. Reset: sizes 1 by 1, loading, no result pending. The element store is
// not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nan_row_omit_compactor_unit import nroc_pkg::*; #(
  parameter int ROWS_MAX = 256,
  parameter int COLS_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [WORD_W-1:0]     value_bits,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_strobe,
  output logic [WORD_W-1:0]     out_bits,
  output logic                  is_last,
  output logic                  status,
  output logic [ROW_CNT_W-1:0]  kept_rows
);

  nroc_cmd_t cmd;
  nroc_sts_t sts;
  logic      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && (cfg_index inside {CFG_ROW_COUNT, CFG_COLUMN_COUNT});

  nroc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .start   (start),
    .req_type(req_type),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  nroc_datapath #(
    .ROWS_MAX(ROWS_MAX),
    .COLS_MAX(COLS_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .value_bits   (value_bits),
    .cmd          (cmd),
    .sts          (sts),
    .result_strobe(result_strobe),
    .out_bits     (out_bits),
    .is_last      (is_last),
    .status       (status),
    .kept_rows    (kept_rows)
  );

  `NROC_ASSERT(a_last_is_data, result_strobe |-> !(is_last && status), "last beat with no-data status")
  `NROC_ASSERT(a_strobe_cause, result_strobe |-> $past(busy || (start && req_type)), "result without request")
  `NROC_ASSERT(a_data_has_rows, (result_strobe && !status) |-> (kept_rows != '0), "data beat with zero kept rows")
  `NROC_ASSERT_RST(a_reset_idle, rst |=> (!result_strobe && !busy), "not idle after reset")

endmodule
